/* hw/rtl/adbi_pkg.sv */
// ----------------------------------------------------------------------------
// adbi_pkg
// shared widths, constants, state and step types of the dead-band double
// integrator
// ----------------------------------------------------------------------------
package adbi_pkg;

  // field widths
  localparam int unsigned ACC_W  = 16;
  localparam int unsigned DT_W   = 16;
  localparam int unsigned DB_W   = 15;
  localparam int unsigned VEL_W  = 32;
  localparam int unsigned POS_W  = 48;

  // configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // register word indexes, taken from paddr[2]
  localparam logic REG_DEADBAND = 1'b0;

  localparam logic [DB_W-1:0] DEADBAND_RST = 15'd82;

  // fraction shifts of the two products
  localparam int unsigned VFRAC_SH = 12;
  localparam int unsigned PFRAC_SH = 16;

  // saturation limits
  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_MEAN,
    ST_VMUL,
    ST_VADD,
    ST_PMUL,
    ST_PADD,
    ST_DONE
  } adbi_state_e;

  // one strobe per lane step
  typedef struct packed {
    logic load;
    logic sum;
    logic div;
    logic mean;
    logic vmul;
    logic vadd;
    logic pmul;
    logic padd;
  } adbi_step_t;

endpackage

/* hw/rtl/adbi_lane.sv */
// ----------------------------------------------------------------------------
// adbi_lane
// one axis: sample window, running sum, mean, dead band, velocity and
// position integration
// ----------------------------------------------------------------------------
module adbi_lane import adbi_pkg::*; #(
  parameter int unsigned WINDOW = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  adbi_step_t                    step_i,
  input  logic [$clog2(WINDOW)-1:0]     slot_i,
  input  logic signed [ACC_W-1:0]       sample_i,
  input  logic [DT_W-1:0]               dt_i,
  input  logic [DB_W-1:0]               deadband_i,
  output logic signed [ACC_W-1:0]       mean_o,
  output logic signed [VEL_W-1:0]       vel_o,
  output logic signed [POS_W-1:0]       pos_o
);

  localparam int unsigned SLOT_W   = $clog2(WINDOW);
  localparam int unsigned SUM_W    = ACC_W + SLOT_W;
  localparam int unsigned DIV_SH   = SUM_W + SLOT_W;
  localparam int unsigned RECIP_W  = SUM_W + 1;
  localparam int unsigned PROD_W   = SUM_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << DIV_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
  localparam int unsigned VPROD_W  = ACC_W + DT_W + 1;
  localparam int unsigned PPROD_W  = VEL_W + DT_W + 1;
  localparam int unsigned VINC_W   = VPROD_W - VFRAC_SH;
  localparam int unsigned PINC_W   = PPROD_W - PFRAC_SH;
  localparam int unsigned VSUM_W   = VEL_W + 1;
  localparam int unsigned PSUM_W   = POS_W + 1;

  // sample window
  logic [ACC_W-1:0] mem_q [WINDOW];
  logic [WINDOW-1:0] vld_q;
  logic [ACC_W-1:0] rd_q;
  logic             rd_vld_q;

  logic signed [ACC_W-1:0]   sample_q;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic [SUM_W-1:0]          sum_abs;
  logic [PROD_W-1:0]         prod_q, prod_d;
  logic                      neg_q;
  logic [ACC_W-1:0]          mean_mag;
  logic signed [ACC_W-1:0]   mean_q, mean_d;
  logic [ACC_W-1:0]          mean_abs;
  logic                      en_q, en_d;
  logic signed [ACC_W-1:0]   old_s;
  logic signed [DT_W:0]      dt_s;
  logic signed [VPROD_W-1:0] vprod_q, vprod_d, vround, vbias;
  logic signed [VINC_W-1:0]  vinc;
  logic signed [VSUM_W-1:0]  vsum;
  logic signed [VEL_W-1:0]   vel_q, vel_d, vsat;
  logic signed [PPROD_W-1:0] pprod_q, pprod_d, pround, pbias;
  logic signed [PINC_W-1:0]  pinc;
  logic signed [PSUM_W-1:0]  psum;
  logic signed [POS_W-1:0]   pos_q, pos_d, psat;

  // window memory, old entry read before it is overwritten
  always_ff @(posedge clk_i) begin
    if (step_i.load) begin
      mem_q[slot_i] <= sample_i;
      rd_q          <= mem_q[slot_i];
      sample_q      <= sample_i;
    end
  end

  // slots never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else if (step_i.load) begin
      vld_q[slot_i] <= 1'b1;
      rd_vld_q      <= vld_q[slot_i];
    end
  end

  assign old_s = rd_vld_q ? signed'(rd_q) : '0;
  assign sum_d = sum_q - SUM_W'(old_s) + SUM_W'(sample_q);

  // truncating divide by the window length: magnitude times reciprocal
  assign sum_abs  = sum_q[SUM_W-1] ? unsigned'(-sum_q) : unsigned'(sum_q);
  assign prod_d   = PROD_W'(sum_abs) * PROD_W'(RECIP);
  assign mean_mag = prod_q[DIV_SH +: ACC_W];
  assign mean_d   = neg_q ? -signed'(mean_mag) : signed'(mean_mag);

  // dead band, most negative mean has full magnitude
  assign mean_abs = mean_q[ACC_W-1] ? unsigned'(-mean_q) : unsigned'(mean_q);
  assign en_d     = mean_abs >= {1'b0, deadband_i};

  assign dt_s    = signed'({1'b0, dt_i});
  assign vprod_d = VPROD_W'(mean_q) * VPROD_W'(dt_s);
  assign pprod_d = PPROD_W'(vel_q) * PPROD_W'(dt_s);

  // velocity update, shift rounds toward zero
  assign vround = vprod_q[VPROD_W-1] ? VPROD_W'((64'd1 << VFRAC_SH) - 64'd1) : '0;
  assign vbias  = vprod_q + vround;
  assign vinc   = signed'(vbias[VPROD_W-1 -: VINC_W]);
  assign vsum   = VSUM_W'(vel_q) + VSUM_W'(vinc);
  assign vsat   = (vsum[VSUM_W-1] != vsum[VSUM_W-2]) ?
                  (vsum[VSUM_W-1] ? VEL_MIN : VEL_MAX) : vsum[VEL_W-1:0];
  assign vel_d  = en_q ? vsat : vel_q;

  // position update
  assign pround = pprod_q[PPROD_W-1] ? PPROD_W'((64'd1 << PFRAC_SH) - 64'd1) : '0;
  assign pbias  = pprod_q + pround;
  assign pinc   = signed'(pbias[PPROD_W-1 -: PINC_W]);
  assign psum   = PSUM_W'(pos_q) + PSUM_W'(pinc);
  assign psat   = (psum[PSUM_W-1] != psum[PSUM_W-2]) ?
                  (psum[PSUM_W-1] ? POS_MIN : POS_MAX) : psum[POS_W-1:0];
  assign pos_d  = psat;

  always_ff @(posedge clk_i) begin
    if (step_i.div) begin
      prod_q <= prod_d;
      neg_q  <= sum_q[SUM_W-1];
    end
    if (step_i.mean) begin
      mean_q <= mean_d;
    end
    if (step_i.vmul) begin
      vprod_q <= vprod_d;
      en_q    <= en_d;
    end
    if (step_i.pmul) begin
      pprod_q <= pprod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      vel_q <= '0;
      pos_q <= '0;
    end else begin
      if (step_i.sum) begin
        sum_q <= sum_d;
      end
      if (step_i.vadd) begin
        vel_q <= vel_d;
      end
      if (step_i.padd) begin
        pos_q <= pos_d;
      end
    end
  end

  assign mean_o = mean_q;
  assign vel_o  = vel_q;
  assign pos_o  = pos_q;

endmodule

/* hw/rtl/accel_deadband_double_integrator.sv */
// ----------------------------------------------------------------------------
// accel_deadband_double_integrator
// two-axis moving average with dead band and saturating double integration
// ----------------------------------------------------------------------------
// sequencing: the step sequencer walks both lanes through sum, divide, mean
//   and the two multiply-add steps; a new item is taken only after the last
//   result has moved into the output register
// reset: windows, sums, velocities and positions read as zero, deadband 82;
//   no clearing pass, window slots carry valid bits
module accel_deadband_double_integrator import adbi_pkg::*; #(
  parameter int unsigned WINDOW = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [ACC_W-1:0]  accel_x_i,
  input  logic signed [ACC_W-1:0]  accel_y_i,
  input  logic [DT_W-1:0]          time_step_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [ACC_W-1:0]  filtered_x_o,
  output logic signed [ACC_W-1:0]  filtered_y_o,
  output logic signed [VEL_W-1:0]  vel_x_o,
  output logic signed [VEL_W-1:0]  vel_y_o,
  output logic signed [POS_W-1:0]  pos_x_o,
  output logic signed [POS_W-1:0]  pos_y_o,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready
);

  localparam int unsigned SLOT_W = $clog2(WINDOW);

  adbi_state_e state_q, state_d;
  adbi_step_t  step;

  logic              in_xfer;
  logic              out_load;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [DT_W-1:0]   dt_q;
  logic [DB_W-1:0]   deadband_q;
  logic              cfg_wr;

  logic signed [ACC_W-1:0] mean_x, mean_y;
  logic signed [VEL_W-1:0] vel_x, vel_y;
  logic signed [POS_W-1:0] pos_x, pos_y;

  logic                    out_valid_q, out_valid_d;
  logic signed [ACC_W-1:0] filt_x_q, filt_y_q;
  logic signed [VEL_W-1:0] vel_x_q, vel_y_q;
  logic signed [POS_W-1:0] pos_x_q, pos_y_q;

  // ---------------------------------------------------------------------------
  // configuration: single deadband register, selected by the word address bit
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DEADBAND);
  assign prdata = (paddr[2] == REG_DEADBAND) ? APB_DW'(deadband_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= DEADBAND_RST;
    end else if (cfg_wr) begin
      deadband_q <= pwdata[DB_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // step sequencer: one item at a time, the input is held off until the
  // result has moved into the output register
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_SUM;
      end
      ST_SUM:  state_d = ST_DIV;
      ST_DIV:  state_d = ST_MEAN;
      ST_MEAN: state_d = ST_VMUL;
      ST_VMUL: state_d = ST_VADD;
      ST_VADD: state_d = ST_PMUL;
      ST_PMUL: state_d = ST_PADD;
      ST_PADD: state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    step     = '0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: step.load = in_xfer;
      ST_SUM:  step.sum  = 1'b1;
      ST_DIV:  step.div  = 1'b1;
      ST_MEAN: step.mean = 1'b1;
      ST_VMUL: step.vmul = 1'b1;
      ST_VADD: step.vadd = 1'b1;
      ST_PMUL: step.pmul = 1'b1;
      ST_PADD: step.padd = 1'b1;
      ST_DONE: out_load  = !out_valid_q || !out_stall_i;
      default: step      = '0;
    endcase
  end

  // window slot shared by both lanes, advances once per transfer
  assign slot_d = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        slot_q <= slot_d;
      end
    end
  end

  // time step held for both multiply steps
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      dt_q <= time_step_i;
    end
  end

  // ---------------------------------------------------------------------------
  // lanes: x and y run the same steps side by side
  // ---------------------------------------------------------------------------
  adbi_lane #(
    .WINDOW(WINDOW)
  ) u_lane_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .slot_i     (slot_q),
    .sample_i   (accel_x_i),
    .dt_i       (dt_q),
    .deadband_i (deadband_q),
    .mean_o     (mean_x),
    .vel_o      (vel_x),
    .pos_o      (pos_x)
  );

  adbi_lane #(
    .WINDOW(WINDOW)
  ) u_lane_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .slot_i     (slot_q),
    .sample_i   (accel_y_i),
    .dt_i       (dt_q),
    .deadband_i (deadband_q),
    .mean_o     (mean_y),
    .vel_o      (vel_y),
    .pos_o      (pos_y)
  );

  // ---------------------------------------------------------------------------
  // merge: both lanes land in one output register, held while stalled
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      filt_x_q <= mean_x;
      filt_y_q <= mean_y;
      vel_x_q  <= vel_x;
      vel_y_q  <= vel_y;
      pos_x_q  <= pos_x;
      pos_y_q  <= pos_y;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign filtered_x_o = filt_x_q;
  assign filtered_y_o = filt_y_q;
  assign vel_x_o      = vel_x_q;
  assign vel_y_o      = vel_y_q;
  assign pos_x_o      = pos_x_q;
  assign pos_y_o      = pos_y_q;

endmodule

/* hw/rtl/adbi_checker.sv */
// ----------------------------------------------------------------------------
// adbi_checker
// port-level checks of the dead-band double integrator, bound to the top
// ----------------------------------------------------------------------------
module adbi_checker import adbi_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [ACC_W-1:0]  filtered_x_o,
  input logic signed [ACC_W-1:0]  filtered_y_o,
  input logic signed [VEL_W-1:0]  vel_x_o,
  input logic signed [VEL_W-1:0]  vel_y_o,
  input logic signed [POS_W-1:0]  pos_x_o,
  input logic signed [POS_W-1:0]  pos_y_o,
  input logic                     psel,
  input logic                     penable,
  input logic                     pwrite,
  input logic [APB_AW-1:0]        paddr,
  input logic [APB_DW-1:0]        pwdata,
  input logic [APB_DW-1:0]        prdata,
  input logic                     pready
);

  // one item in flight: the input is held off right after a transfer
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while an item is in flight");

  // deadband write reads back
  a_deadband_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && (paddr[2] == REG_DEADBAND))
      ##1 (paddr[2] == REG_DEADBAND)
      |-> (prdata == APB_DW'($past(pwdata[DB_W-1:0]))))
    else $error("deadband readback mismatch");

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

  a_out_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_payload_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(filtered_x_o) && $stable(filtered_y_o) && $stable(vel_x_o) &&
       $stable(vel_y_o) && $stable(pos_x_o) && $stable(pos_y_o)))
    else $error("result changed while stalled");

endmodule

bind accel_deadband_double_integrator adbi_checker u_adbi_checker (.*);
